### rtl/core/fpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpm_pkg
// Shared types and constants for the polynomial multiplier: controller
// states, the datapath command and status words, and fixed field widths.
// ----------------------------------------------------------------------------
package fpm_pkg;

  // Fixed widths of the port fields.
  localparam int unsigned DEG_W   = 5;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned COEF_W  = 8;
  localparam int unsigned PIDX_W  = 6;
  localparam int unsigned PVAL_W  = 21;
  localparam int unsigned PROD_W  = 2 * COEF_W;
  localparam int unsigned LEN_W   = 7;

  // Input word commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // Polynomial select on a load.
  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;

  // Configuration register indexes.
  localparam logic REG_A_DEGREE = 1'b0;
  localparam logic REG_B_DEGREE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } fpm_state_t;

  // Controller to datapath command word.
  typedef struct packed {
    logic               wr_en;
    logic               wr_sel;
    logic [IDX_W-1:0]   wr_addr;
    logic [COEF_W-1:0]  wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_a;
    logic [IDX_W-1:0]   rd_b;
    logic               match;
    logic               first;
    logic               fin;
    logic [PIDX_W-1:0]  out_idx;
    logic               out_last;
  } fpm_cmd_t;

  // Datapath to controller status word.
  typedef struct packed {
    logic busy;
  } fpm_sts_t;

endpackage

### rtl/core/fft_polynomial_multiply_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_polynomial_multiply_top
// Integer polynomial multiplier with a load/run command word interface.
// ----------------------------------------------------------------------------
// A load word writes one coefficient of A or B and is accepted
// back to back. A run word computes the product coefficients 0 up to
// a_degree+b_degree (wrapped modulo FFT_POINTS when longer) with a single
// 8x8 multiply-accumulate unit fed from the coefficient stores. Each output
// coefficient scans all (da+1)*(db+1) coefficient pairs, one per cycle, then
// drains the three-stage pipeline and waits for its word to be taken.
// No input word is accepted during a run. Every coefficient up to the
// configured degrees must be loaded before a run.
module fft_polynomial_multiply_top import fpm_pkg::*; #(
  parameter int unsigned FFT_POINTS = 64,
  parameter int unsigned MAX_TERMS  = 32,
  parameter int unsigned COEFF_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic               in_poly_sel,
  input  logic [IDX_W-1:0]   in_coeff_index,
  input  logic [COEF_W-1:0]  in_coeff_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIDX_W-1:0]  out_product_index,
  output logic [PVAL_W-1:0]  out_product_value,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [DEG_W-1:0]   cfg_data
);

  fpm_cmd_t cmd;
  fpm_sts_t sts;

  fpm_ctrl #(
    .FFT_POINTS (FFT_POINTS),
    .MAX_TERMS  (MAX_TERMS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_poly_sel    (in_poly_sel),
    .in_coeff_index (in_coeff_index),
    .in_coeff_value (in_coeff_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts)
  );

  fpm_datapath #(
    .MAX_TERMS  (MAX_TERMS),
    .COEFF_BITS (COEFF_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_product_index (out_product_index),
    .out_product_value (out_product_value),
    .out_last          (out_last)
  );

  // No result word is pending while input words are taken.
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("result pending while accepting input");

  // Once a result word is taken, the next one needs a fresh scan.
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result word repeated");

  // The datapath is never busy while the sequencer is idle.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.busy)
    else $error("pipeline active while idle");

endmodule

### rtl/core/fpm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpm_datapath
// Coefficient stores, the shared multiply-accumulate pipeline and the
// output word register.
// ----------------------------------------------------------------------------
module fpm_datapath import fpm_pkg::*; #(
  parameter int unsigned MAX_TERMS  = 32,
  parameter int unsigned COEFF_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fpm_cmd_t             cmd,
  output fpm_sts_t             sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIDX_W-1:0]    out_product_index,
  output logic [PVAL_W-1:0]    out_product_value,
  output logic                 out_last
);

  localparam int unsigned AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [COEF_W-1:0] CMASK =
    (COEFF_BITS >= COEF_W) ? {COEF_W{1'b1}} : COEF_W'((1 << COEFF_BITS) - 1);

  logic [COEF_W-1:0] a_mem [MAX_TERMS];
  logic [COEF_W-1:0] b_mem [MAX_TERMS];

  // Stage 1: registered reads.
  logic [COEF_W-1:0] a_q_r, b_q_r;
  logic              s1_v_r, s1_match_r, s1_first_r, s1_fin_r, s1_last_r;
  logic [PIDX_W-1:0] s1_idx_r;
  // Stage 2: registered product.
  logic [PROD_W-1:0] prod_r;
  logic              s2_v_r, s2_first_r, s2_fin_r, s2_last_r;
  logic [PIDX_W-1:0] s2_idx_r;
  // Stage 3: accumulator and output word.
  logic [PVAL_W-1:0] acc_r, acc_nxt;
  logic              out_valid_r;
  logic [PVAL_W-1:0] out_value_r;
  logic [PIDX_W-1:0] out_idx_r;
  logic              out_last_r;

  // Store writes and reads; loads beyond the store are dropped.
  always_ff @(posedge clk) begin
    if (cmd.wr_en && (32'(cmd.wr_addr) < MAX_TERMS)) begin
      if (cmd.wr_sel == SEL_A) begin
        a_mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data & CMASK;
      end else begin
        b_mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data & CMASK;
      end
    end
    if (cmd.rd_en) begin
      a_q_r <= a_mem[cmd.rd_a[AW-1:0]];
      b_q_r <= b_mem[cmd.rd_b[AW-1:0]];
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.rd_en;
      s2_v_r <= s1_v_r;
    end
  end

  // Term flags follow the data through the stages.
  always_ff @(posedge clk) begin
    s1_match_r <= cmd.match;
    s1_first_r <= cmd.first;
    s1_fin_r   <= cmd.fin;
    s1_last_r  <= cmd.out_last;
    s1_idx_r   <= cmd.out_idx;
    prod_r     <= s1_match_r ? (PROD_W'(a_q_r) * PROD_W'(b_q_r)) : '0;
    s2_first_r <= s1_first_r;
    s2_fin_r   <= s1_fin_r;
    s2_last_r  <= s1_last_r;
    s2_idx_r   <= s1_idx_r;
  end

  // The sum keeps its low bits only.
  assign acc_nxt = (s2_first_r ? '0 : acc_r) + PVAL_W'(prod_r);

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      acc_r <= acc_nxt;
    end
    if (s2_v_r && s2_fin_r) begin
      out_value_r <= acc_nxt;
      out_idx_r   <= s2_idx_r;
      out_last_r  <= s2_last_r;
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_v_r && s2_fin_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.busy          = s1_v_r | s2_v_r | out_valid_r;
  assign out_valid         = out_valid_r;
  assign out_product_index = out_idx_r;
  assign out_product_value = out_value_r;
  assign out_last          = out_last_r;

endmodule

### rtl/core/fpm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpm_ctrl
// Sequencer: holds the degree registers, takes load and run words and
// walks the coefficient pairs of every product term.
// ----------------------------------------------------------------------------
module fpm_ctrl import fpm_pkg::*; #(
  parameter int unsigned FFT_POINTS = 64,
  parameter int unsigned MAX_TERMS  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic               in_poly_sel,
  input  logic [IDX_W-1:0]   in_coeff_index,
  input  logic [COEF_W-1:0]  in_coeff_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [DEG_W-1:0]   cfg_data,
  output fpm_cmd_t           cmd,
  input  fpm_sts_t           sts
);

  localparam int unsigned NW = $clog2(FFT_POINTS);
  localparam logic [DEG_W-1:0] DMAX = DEG_W'(MAX_TERMS - 1);
  localparam logic [LEN_W-1:0] NPTS = LEN_W'(FFT_POINTS);

  fpm_state_t        state_r, state_nxt;
  logic [DEG_W-1:0]  a_deg_r, b_deg_r;
  logic [DEG_W-1:0]  da_r, da_nxt, db_r, db_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [NW-1:0]     k_r, k_nxt, m_r, m_nxt, mi_r, mi_nxt;
  logic [DEG_W-1:0]  da_c, db_c;
  logic [LEN_W-1:0]  sum_c;
  logic [NW-1:0]     mi_inc, m_inc;
  logic              k_last;

  // Degree registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_deg_r <= '0;
      b_deg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_A_DEGREE) begin
        a_deg_r <= cfg_data;
      end else begin
        b_deg_r <= cfg_data;
      end
    end
  end
  assign cfg_ready = 1'b1;

  // Degrees beyond the store saturate; the length is capped at the size.
  assign da_c  = (32'(a_deg_r) >= MAX_TERMS) ? DMAX : a_deg_r;
  assign db_c  = (32'(b_deg_r) >= MAX_TERMS) ? DMAX : b_deg_r;
  assign sum_c = LEN_W'(da_c) + LEN_W'(db_c) + LEN_W'(1);

  // Index arithmetic modulo the transform size.
  assign mi_inc = (32'(mi_r) + 1 == FFT_POINTS) ? '0 : mi_r + NW'(1);
  assign m_inc  = (32'(m_r) + 1 == FFT_POINTS) ? '0 : m_r + NW'(1);
  assign k_last = (LEN_W'(k_r) + LEN_W'(1)) == len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    da_r  <= da_nxt;
    db_r  <= db_nxt;
    len_r <= len_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    m_r   <= m_nxt;
    mi_r  <= mi_nxt;
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    da_nxt    = da_r;
    db_nxt    = db_r;
    len_nxt   = len_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    m_nxt     = m_r;
    mi_nxt    = mi_r;
    in_ready  = 1'b0;
    cmd          = '0;
    cmd.wr_sel   = in_poly_sel;
    cmd.wr_addr  = in_coeff_index;
    cmd.wr_data  = in_coeff_value;
    cmd.rd_a     = i_r;
    cmd.rd_b     = j_r;
    cmd.match    = (m_r == k_r);
    cmd.first    = (i_r == '0) && (j_r == '0);
    cmd.fin      = (i_r == IDX_W'(da_r)) && (j_r == IDX_W'(db_r));
    cmd.out_idx  = PIDX_W'(k_r);
    cmd.out_last = k_last;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_LOAD) begin
            cmd.wr_en = 1'b1;
          end else begin
            da_nxt    = da_c;
            db_nxt    = db_c;
            len_nxt   = (sum_c > NPTS) ? NPTS : sum_c;
            i_nxt     = '0;
            j_nxt     = '0;
            k_nxt     = '0;
            m_nxt     = '0;
            mi_nxt    = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cmd.fin) begin
          state_nxt = ST_DRAIN;
        end else if (j_r == IDX_W'(db_r)) begin
          j_nxt  = '0;
          i_nxt  = i_r + IDX_W'(1);
          mi_nxt = mi_inc;
          m_nxt  = mi_inc;
        end else begin
          j_nxt = j_r + IDX_W'(1);
          m_nxt = m_inc;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          if (k_last) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + NW'(1);
            i_nxt     = '0;
            j_nxt     = '0;
            m_nxt     = '0;
            mi_nxt    = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### test/fft_polynomial_multiply_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_polynomial_multiply_top_tb
// Self-checking bench for the polynomial multiplier. Coefficient loads and
// run words go in through a queue-fed driver. Each run's product
// coefficients are predicted as the exact linear convolution of the loaded
// stores. A monitor compares every product word in order. Both sides stall
// at random, and the degree registers change between phases.
// ----------------------------------------------------------------------------
module fft_polynomial_multiply_top_tb;
  import fpm_pkg::*;

  localparam int unsigned TERMS      = 32;
  localparam int unsigned CYCLE_CAP  = 3000000;

  typedef struct packed {
    logic              cmd;
    logic              sel;
    logic [IDX_W-1:0]  idx;
    logic [COEF_W-1:0] val;
  } load_word_t;

  typedef struct packed {
    logic [PIDX_W-1:0] idx;
    logic [PVAL_W-1:0] val;
    logic              last;
  } product_word_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_cmd;
  logic               in_poly_sel;
  logic [IDX_W-1:0]   in_coeff_index;
  logic [COEF_W-1:0]  in_coeff_value;
  logic               out_valid;
  logic               out_ready;
  logic [PIDX_W-1:0]  out_product_index;
  logic [PVAL_W-1:0]  out_product_value;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [DEG_W-1:0]   cfg_data;

  fft_polynomial_multiply_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_poly_sel       (in_poly_sel),
    .in_coeff_index    (in_coeff_index),
    .in_coeff_value    (in_coeff_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_product_index (out_product_index),
    .out_product_value (out_product_value),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Words waiting to be driven and products waiting to arrive.
  load_word_t    pending_words[$];
  product_word_t products_due[$];

  // Predictor copy of the block's state.
  logic [COEF_W-1:0] store_a [TERMS];
  logic [COEF_W-1:0] store_b [TERMS];
  logic [DEG_W-1:0]  deg_a;
  logic [DEG_W-1:0]  deg_b;

  // Generator-side record of which coefficients have been loaded.
  bit written_a [TERMS];
  bit written_b [TERMS];

  int unsigned words_queued;
  int unsigned words_taken;
  int unsigned runs_taken;
  int unsigned products_seen;
  int unsigned cycles;
  int unsigned errors;
  bit          steady;

  // Clock and a single reset at the start.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Predict the product coefficients of one run: exact linear convolution.
  task automatic predict_products();
    logic [PVAL_W+3:0] sums [64];
    int n;
    n = int'(deg_a) + int'(deg_b) + 1;
    for (int k = 0; k < 64; k++) sums[k] = '0;
    for (int i = 0; i <= int'(deg_a); i++)
      for (int j = 0; j <= int'(deg_b); j++)
        sums[i + j] += store_a[i] * store_b[j];
    for (int k = 0; k < n; k++) begin
      product_word_t w;
      w.idx  = PIDX_W'(k);
      w.val  = sums[k][PVAL_W-1:0];
      w.last = (k == n - 1);
      products_due.push_back(w);
    end
  endtask

  // Driver: present the next word, idling at random unless in a steady stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_cmd         <= CMD_LOAD;
      in_poly_sel    <= SEL_A;
      in_coeff_index <= '0;
      in_coeff_value <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() > 0 && (steady || $urandom_range(99) >= 34)) begin
        load_word_t w;
        w = pending_words.pop_front();
        in_valid       <= 1'b1;
        in_cmd         <= w.cmd;
        in_poly_sel    <= w.sel;
        in_coeff_index <= w.idx;
        in_coeff_value <= w.val;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: track accepted words and registers, check every product word.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      deg_a     <= '0;
      deg_b     <= '0;
      for (int i = 0; i < TERMS; i++) begin
        store_a[i] = '0;
        store_b[i] = '0;
      end
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 34);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_A_DEGREE) deg_a <= cfg_data;
        else deg_b <= cfg_data;
      end
      if (in_valid && in_ready) begin
        words_taken++;
        if (in_cmd == CMD_LOAD) begin
          if (in_poly_sel == SEL_A) store_a[in_coeff_index] = in_coeff_value;
          else store_b[in_coeff_index] = in_coeff_value;
        end else begin
          runs_taken++;
          predict_products();
        end
      end
      if (out_valid && out_ready) begin
        products_seen++;
        if (products_due.size() == 0) begin
          $error("product word with none expected: index %0d value %0d",
                 out_product_index, out_product_value);
          errors++;
        end else begin
          product_word_t w;
          w = products_due.pop_front();
          if (out_product_index !== w.idx) begin
            $error("product_index: expected %0d, got %0d", w.idx, out_product_index);
            errors++;
          end
          if (out_product_value !== w.val) begin
            $error("product_value: expected %0d, got %0d", w.val, out_product_value);
            errors++;
          end
          if (out_last !== w.last) begin
            $error("last: expected %0d, got %0d", w.last, out_last);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic queue_load(input logic sel, input int idx, input int val);
    load_word_t w;
    w.cmd = CMD_LOAD;
    w.sel = sel;
    w.idx = IDX_W'(idx);
    w.val = COEF_W'(val);
    if (sel == SEL_A) written_a[idx] = 1'b1;
    else written_b[idx] = 1'b1;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // A run word; any coefficient in range that was never loaded is loaded first.
  task automatic queue_run(input int da, input int db);
    load_word_t w;
    for (int i = 0; i <= da; i++)
      if (!written_a[i]) queue_load(SEL_A, i, $urandom_range(255));
    for (int i = 0; i <= db; i++)
      if (!written_b[i]) queue_load(SEL_B, i, $urandom_range(255));
    w.cmd = CMD_RUN;
    w.sel = 1'($urandom_range(1));
    w.idx = IDX_W'($urandom_range(31));
    w.val = COEF_W'($urandom_range(255));
    pending_words.push_back(w);
    words_queued++;
  endtask

  // Hold the sender until every queued word is taken and every product is in.
  task automatic wait_drained();
    while (words_taken != words_queued || products_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= DEG_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_degrees(input int da, input int db);
    wait_drained();
    write_reg(REG_A_DEGREE, da);
    write_reg(REG_B_DEGREE, db);
  endtask

  // Stimulus: directed phases, random phases, then a full-size run.
  initial begin
    int da;
    int db;
    int phase;
    cfg_valid    = 1'b0;
    cfg_index    = REG_A_DEGREE;
    cfg_data     = '0;
    steady       = 1'b0;
    words_queued = 0;
    words_taken  = 0;
    runs_taken   = 0;
    products_seen = 0;
    cycles       = 0;
    errors       = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    @(posedge clk);

    // Degrees zero: the largest single product, then a zero operand.
    set_degrees(0, 0);
    queue_load(SEL_A, 0, 255);
    queue_load(SEL_B, 0, 255);
    queue_run(0, 0);
    queue_load(SEL_A, 0, 0);
    queue_run(0, 0);

    // Small mixed degrees; loads to the top index lie beyond both degrees.
    set_degrees(3, 1);
    queue_load(SEL_A, 0, 1);
    queue_load(SEL_A, 1, 2);
    queue_load(SEL_A, 2, 128);
    queue_load(SEL_A, 3, 255);
    queue_load(SEL_B, 0, 127);
    queue_load(SEL_B, 1, 1);
    queue_load(SEL_B, 31, 170);
    queue_load(SEL_A, 31, 85);
    queue_run(3, 1);
    queue_run(3, 1);

    // Random phases; the first two run with no stalls at all.
    phase = 0;
    while (words_queued < 60) begin
      int n;
      phase++;
      if ($urandom_range(7) == 0) begin
        da = $urandom_range(31);
        db = $urandom_range(3);
      end else begin
        da = $urandom_range(6);
        db = $urandom_range(6);
      end
      set_degrees(da, db);
      steady = (phase <= 2);
      n = $urandom_range(10, 2);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(4) == 0)
          queue_load(1'($urandom_range(1)), $urandom_range(31), $urandom_range(255));
        else if ($urandom_range(1) == 0)
          queue_load(SEL_A, $urandom_range(da), $urandom_range(255));
        else
          queue_load(SEL_B, $urandom_range(db), $urandom_range(255));
      end
      queue_run(da, db);
      if ($urandom_range(2) == 0) queue_run(da, db);
    end

    // Both degrees at the top with every coefficient at its maximum.
    set_degrees(31, 31);
    steady = 1'b0;
    for (int i = 0; i < TERMS; i++) begin
      queue_load(SEL_A, i, 255);
      queue_load(SEL_B, i, 255);
    end
    queue_run(31, 31);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d words with %0d runs, degrees 0 to 31 on both operands,",
             words_taken, runs_taken);
    $display("and checked %0d product words under random stalls.", products_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
